// ===== rtl/tsg_pkg.sv =====
// Shared constants and command/status types of the trapezoidal setpoint generator.
package tsg_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int ACC_W         = 31;
    localparam int POS_W         = 32;
    localparam int NUM_W         = 63;
    localparam int DEN_W         = 33;

    localparam logic [1:0] REG_NOM_VEL_LIN = 2'd0;
    localparam logic [1:0] REG_NOM_VEL_ROT = 2'd1;
    localparam logic [1:0] REG_NOM_ACC_LIN = 2'd2;
    localparam logic [1:0] REG_NOM_ACC_ROT = 2'd3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic AXIS_LIN = 1'b0;
    localparam logic AXIS_ROT = 1'b1;

    typedef struct packed {
        logic axis_sel;
        logic load_goal;
        logic sq_load;
        logic div_start;
        logic accel_calc;
        logic state_update;
        logic publish;
    } tsg_cmd_t;

    typedef struct packed {
        logic div_busy;
    } tsg_status_t;

endpackage

// ===== rtl/tsg_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module tsg_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tsg_pkg::NUM_W-1:0]     dividend,
    input  logic [tsg_pkg::DEN_W-1:0]     divisor,
    output logic                          busy,
    output logic [tsg_pkg::NUM_W-1:0]     quotient
);

    logic [tsg_pkg::NUM_W-1:0] dq_reg;
    logic [tsg_pkg::DEN_W-1:0] rem_reg;
    logic [tsg_pkg::DEN_W-1:0] den_reg;
    logic [5:0]                cnt_reg;
    logic                      busy_reg;
    logic [tsg_pkg::DEN_W:0]   trial;
    logic [tsg_pkg::DEN_W:0]   diff;
    logic                      qbit;

    // Trial subtract of the shifted remainder
    always_comb begin
        trial = {rem_reg, dq_reg[tsg_pkg::NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(tsg_pkg::NUM_W - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    // Shift dividend out and quotient bits in
    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[tsg_pkg::NUM_W-2:0], qbit};
            rem_reg <= qbit ? diff[tsg_pkg::DEN_W-1:0] : trial[tsg_pkg::DEN_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

// ===== rtl/tsg_datapath.sv =====
// Axis state, configuration registers, square, dividers and update arithmetic.
module tsg_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  tsg_pkg::tsg_cmd_t   cmd,
    output tsg_pkg::tsg_status_t status,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_wdata,
    input  logic [63:0]         in_targets,
    output logic [127:0]        out_data,
    output logic                out_moving
);

    logic signed [31:0] pos_reg  [2];
    logic signed [31:0] vel_reg  [2];
    logic signed [31:0] goal_reg [2];
    logic [30:0]        nvel_reg [2];
    logic [30:0]        nacc_reg [2];
    logic               ml_reg;
    logic               moving_reg;
    logic [63:0]        sq_reg;
    logic signed [63:0] a_reg;
    logic [127:0]       out_reg;
    logic               out_moving_reg;

    logic signed [31:0] p, v, g;
    logic [30:0]        acc, nv;
    logic signed [32:0] diff;
    logic [31:0]        gap_mag;
    logic               snap;
    logic [31:0]        vmag;
    logic [63:0]        num64;
    logic               busy0, busy1;
    logic [62:0]        q_stop, q_brake;
    logic signed [63:0] p64, v64, g64, stop, q64, qb64, acc64, nv64, a_next;
    logic signed [63:0] half, psum, vsum;
    logic signed [31:0] pos_sat, vel_sat;

    localparam logic signed [63:0] MAXV = 64'sd2147483647;
    localparam logic signed [63:0] MINV = -64'sd2147483648;

    // Select the axis in work
    always_comb begin
        p    = pos_reg[cmd.axis_sel];
        v    = vel_reg[cmd.axis_sel];
        g    = goal_reg[cmd.axis_sel];
        acc  = nacc_reg[cmd.axis_sel];
        nv   = nvel_reg[cmd.axis_sel];
        diff = {g[31], g} - {p[31], p};
        gap_mag = diff[32] ? 32'(-diff) : diff[31:0];
        snap = ({1'b0, gap_mag} <= {3'b0, acc[30:1]});
        vmag = v[31] ? 32'(-v) : 32'(v);
        num64 = {sq_reg[63:tsg_pkg::FRACTION_BITS], {tsg_pkg::FRACTION_BITS{1'b0}}};
    end

    tsg_divider u_div_stop (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num64[62:0]),
        .divisor  ({1'b0, acc, 1'b0}),
        .busy     (busy0),
        .quotient (q_stop)
    );

    tsg_divider u_div_brake (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num64[62:0]),
        .divisor  ({gap_mag, 1'b0}),
        .busy     (busy1),
        .quotient (q_brake)
    );

    assign status.div_busy = busy0 | busy1;

    // Predict stop point and pick the acceleration
    always_comb begin
        p64   = 64'(p);
        v64   = 64'(v);
        g64   = 64'(g);
        q64   = {1'b0, q_stop};
        qb64  = {1'b0, q_brake};
        acc64 = {33'b0, acc};
        nv64  = {33'b0, nv};
        if (v > 0) begin
            stop = p64 + v64 + q64;
        end else if (v < 0) begin
            stop = p64 + v64 - q64;
        end else begin
            stop = p64 + v64;
        end
        if (p < g) begin
            if (stop > g64) begin
                a_next = -qb64;
            end else if (v64 < nv64) begin
                a_next = (v64 < nv64 - acc64) ? acc64 : (nv64 - v64);
            end else begin
                a_next = '0;
            end
        end else begin
            if (stop < g64) begin
                a_next = qb64;
            end else if (v64 > -nv64) begin
                a_next = (v64 > acc64 - nv64) ? -acc64 : -(nv64 + v64);
            end else begin
                a_next = '0;
            end
        end
    end

    // Advance position and velocity with saturation
    always_comb begin
        half = (a_reg + $signed({63'b0, a_reg[63] & a_reg[0]})) >>> 1;
        psum = p64 + v64 + half;
        vsum = v64 + a_reg;
        if (psum > MAXV) begin
            pos_sat = 32'sh7FFFFFFF;
        end else if (psum < MINV) begin
            pos_sat = 32'sh80000000;
        end else begin
            pos_sat = psum[31:0];
        end
        if (vsum > MAXV) begin
            vel_sat = 32'sh7FFFFFFF;
        end else if (vsum < MINV) begin
            vel_sat = 32'sh80000000;
        end else begin
            vel_sat = vsum[31:0];
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                goal_reg[i] <= '0;
                nvel_reg[i] <= 31'd65536;
                nacc_reg[i] <= 31'd655;
            end
            ml_reg     <= 1'b0;
            moving_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    tsg_pkg::REG_NOM_VEL_LIN: nvel_reg[tsg_pkg::AXIS_LIN] <= cfg_wdata;
                    tsg_pkg::REG_NOM_VEL_ROT: nvel_reg[tsg_pkg::AXIS_ROT] <= cfg_wdata;
                    tsg_pkg::REG_NOM_ACC_LIN: nacc_reg[tsg_pkg::AXIS_LIN] <=
                        (cfg_wdata == '0) ? 31'd1 : cfg_wdata;
                    tsg_pkg::REG_NOM_ACC_ROT: nacc_reg[tsg_pkg::AXIS_ROT] <=
                        (cfg_wdata == '0) ? 31'd1 : cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load_goal) begin
                goal_reg[tsg_pkg::AXIS_LIN] <= in_targets[31:0];
                goal_reg[tsg_pkg::AXIS_ROT] <= in_targets[63:32];
                moving_reg <= 1'b1;
            end
            if (cmd.state_update) begin
                if (snap) begin
                    pos_reg[cmd.axis_sel] <= g;
                    vel_reg[cmd.axis_sel] <= '0;
                end else begin
                    pos_reg[cmd.axis_sel] <= pos_sat;
                    vel_reg[cmd.axis_sel] <= vel_sat;
                end
                if (cmd.axis_sel == tsg_pkg::AXIS_LIN) begin
                    ml_reg <= !snap;
                end else begin
                    moving_reg <= ml_reg | !snap;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.sq_load) begin
            sq_reg <= vmag * vmag;
        end
        if (cmd.accel_calc) begin
            a_reg <= a_next;
        end
        if (cmd.publish) begin
            out_reg <= {vel_reg[tsg_pkg::AXIS_ROT], vel_reg[tsg_pkg::AXIS_LIN],
                        pos_reg[tsg_pkg::AXIS_ROT], pos_reg[tsg_pkg::AXIS_LIN]};
            out_moving_reg <= moving_reg;
        end
    end

    assign out_data   = out_reg;
    assign out_moving = out_moving_reg;

endmodule

// ===== rtl/tsg_ctrl.sv =====
// Sequencer for one item: square, divide, accel, update per axis on tick; publish.
module tsg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_op,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  tsg_pkg::tsg_status_t status,
    output tsg_pkg::tsg_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQUARE, ST_DIV_START, ST_DIV_WAIT, ST_ACCEL, ST_UPDATE, ST_PUBLISH
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    logic   valid_reg, valid_next;
    logic   accept, pub;

    always_comb begin
        accept     = (state_reg == ST_IDLE) && in_valid;
        pub        = (state_reg == ST_PUBLISH) && (!valid_reg || out_ready);
        state_next = state_reg;
        axis_next  = axis_reg;
        valid_next = valid_reg;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    axis_next  = tsg_pkg::AXIS_LIN;
                    state_next = (in_op == tsg_pkg::OP_LOAD) ? ST_PUBLISH : ST_SQUARE;
                end
            end
            ST_SQUARE:    state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_ACCEL;
                end
            end
            ST_ACCEL:     state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (axis_reg == tsg_pkg::AXIS_LIN) begin
                    axis_next  = tsg_pkg::AXIS_ROT;
                    state_next = ST_SQUARE;
                end else begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH: begin
                if (pub) begin
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= tsg_pkg::AXIS_LIN;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            valid_reg <= valid_next;
        end
    end

    // Decode commands for the datapath
    always_comb begin
        cmd.axis_sel     = axis_reg;
        cmd.load_goal    = accept && (in_op == tsg_pkg::OP_LOAD);
        cmd.sq_load      = (state_reg == ST_SQUARE);
        cmd.div_start    = (state_reg == ST_DIV_START);
        cmd.accel_calc   = (state_reg == ST_ACCEL);
        cmd.state_update = (state_reg == ST_UPDATE);
        cmd.publish      = pub;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;

endmodule

// ===== rtl/trapezoidal_setpoint_generator.sv =====
// Sequence: a load beat goes straight to publish; a tick beat runs per axis square,
//   divider start, divider run, acceleration and update, then publish.
// Flow: one beat at a time; a new beat is taken while a finished result still waits
//   in the output register.
// Reset (aresetn low, synchronous): positions, velocities, goals zero, standing,
//   registers at their defaults.
module trapezoidal_setpoint_generator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // target_lin [31:0], target_rot [63:32]
    input  logic         s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // pos_lin, pos_rot, vel_lin, vel_rot (32 bits each)
    output logic         m_tuser,   // status_moving
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_wdata
);

    tsg_pkg::tsg_cmd_t    cmd;
    tsg_pkg::tsg_status_t status;

    tsg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    tsg_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_targets (s_tdata),
        .out_data   (m_tdata),
        .out_moving (m_tuser)
    );

endmodule
